// ===== rtl/core/bae_pkg.sv =====
// bae_pkg: shared types and constants of the bond angle enumerator
// item and result structs, command record between front and back, queue sizes
// no dependencies
package bae_pkg;

  localparam int AtomW       = 10;
  localparam int SlotW       = 2;
  localparam int CountW      = 3;
  localparam int ResultLimit = 12;
  localparam int NumW        = $clog2(ResultLimit + 1);
  localparam int QDepth      = 2;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);

  localparam int DefMaxAtoms = 1024;
  localparam int DefMaxBonds = 4;

  typedef enum logic [0:0] {
    OpLoad = 1'b0,
    OpEnum = 1'b1
  } op_e;

  typedef struct packed {
    op_e               operation;
    logic [AtomW-1:0]  atom;
    logic [SlotW-1:0]  slot;
    logic [AtomW-1:0]  neighbour;
    logic [CountW-1:0] bond_count;
  } in_item_t;

  typedef struct packed {
    logic [AtomW-1:0] first_atom;
    logic [AtomW-1:0] middle_atom;
    logic [AtomW-1:0] end_atom;
    logic             empty_res;
    logic             last;
  } res_item_t;

  // classified command handed from the front to the back
  typedef struct packed {
    op_e               op;
    logic [AtomW-1:0]  atom;
    logic              atom_ok;
    logic [SlotW-1:0]  slot;
    logic              slot_ok;
    logic [AtomW-1:0]  neighbour;
    logic [CountW-1:0] count;
  } cmd_t;

endpackage

// ===== rtl/core/bond_angle_enumerator_top.sv =====
// bond_angle_enumerator_top: top level of the bond angle enumerator
// instantiates bae_cmd_queue, bae_engine and bae_res_queue; depends on bae_pkg
//
// usage
// - input channel is a queue write port: an item is taken on a clock edge with
//   push high and full low. operation load writes one neighbour slot and the
//   atom's bond count and gives no result; operation enumerate names a first
//   atom and gives one or more results
// - result channel is a queue read port: while empty is low the oldest result
//   sits on result_o and is taken on an edge with pop high
// - an enumerate gives every angle first-middle-end with end above first, in
//   slot order, at most 12; the final one has last set. a query with no angle
//   gives one item with empty_res and last set
// - after reset the engine zeroes the bond count memory, one atom per cycle,
//   and full stays high until every atom is cleared
// - a load is handled in the idle state. an enumerate reads the first atom's bond
//   count, then for each neighbour of it the neighbour and its bond count, then
//   each neighbour of that neighbour, one entry at a time through the
//   single registered read port of the neighbour table
// - a two-entry command queue lets loads queue up while a walk runs; when the
//   receiver stalls the result queue fills, the walk pauses, and then the
//   command queue fills and full rises
module bond_angle_enumerator_top #(
  parameter int MAX_ATOMS = bae_pkg::DefMaxAtoms,
  parameter int MAX_BONDS = bae_pkg::DefMaxBonds
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  bae_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output bae_pkg::res_item_t result_o
);
  import bae_pkg::*;

  // front to back command path
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      init_done;

  // back to result queue path
  logic      res_push;
  res_item_t res;
  logic      res_full;

  // front: accept, classify and queue commands
  bae_cmd_queue #(
    .MAX_ATOMS (MAX_ATOMS),
    .MAX_BONDS (MAX_BONDS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .init_done_i (init_done),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: memories and the neighbour walk
  bae_engine #(
    .MAX_ATOMS (MAX_ATOMS),
    .MAX_BONDS (MAX_BONDS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .init_done_o (init_done),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  // results wait here for the receiver
  bae_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (result_o)
  );

endmodule

// ===== rtl/core/bae_cmd_queue.sv =====
// bae_cmd_queue: front part, accepts input items, range-checks and clamps them
// and holds them in a two-entry command queue for the engine
// depends on bae_pkg
module bae_cmd_queue #(
  parameter int MAX_ATOMS = bae_pkg::DefMaxAtoms,
  parameter int MAX_BONDS = bae_pkg::DefMaxBonds
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bae_pkg::in_item_t item_i,
  output logic              full_o,
  input  logic              init_done_i,
  output logic              cmd_valid_o,
  output bae_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);
  import bae_pkg::*;

  cmd_t             q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;
  cmd_t             cmd_new;

  // classify the incoming item
  always_comb begin
    cmd_new.op        = item_i.operation;
    cmd_new.atom      = item_i.atom;
    cmd_new.atom_ok   = (32'(item_i.atom) < 32'(MAX_ATOMS));
    cmd_new.slot      = item_i.slot;
    cmd_new.slot_ok   = (32'(item_i.slot) < 32'(MAX_BONDS));
    cmd_new.neighbour = item_i.neighbour;
    if (32'(item_i.bond_count) > 32'(MAX_BONDS)) begin
      cmd_new.count = CountW'(MAX_BONDS);
    end else begin
      cmd_new.count = item_i.bond_count;
    end
  end

  assign full_o      = (cnt_q == QCntW'(QDepth)) || !init_done_i;
  assign do_push     = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/core/bae_engine.sv =====
// bae_engine: back part, owns the neighbour table and bond count memories,
// clears the counts after reset, applies loads and walks neighbours of neighbours per query
// depends on bae_pkg
module bae_engine #(
  parameter int MAX_ATOMS = bae_pkg::DefMaxAtoms,
  parameter int MAX_BONDS = bae_pkg::DefMaxBonds
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  bae_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               init_done_o,
  output logic               res_push_o,
  output bae_pkg::res_item_t res_o,
  input  logic               res_full_i
);
  import bae_pkg::*;

  localparam int AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int NbAw = $clog2(MAX_ATOMS * MAX_BONDS);

  localparam logic [2:0] SClear  = 3'd0;
  localparam logic [2:0] SIdle   = 3'd1;
  localparam logic [2:0] SCnt1   = 3'd2;
  localparam logic [2:0] SNb1    = 3'd3;
  localparam logic [2:0] SCnt2   = 3'd4;
  localparam logic [2:0] SNb2    = 3'd5;
  localparam logic [2:0] SFinish = 3'd6;

  // memories
  logic [CountW-1:0] cnt_mem [MAX_ATOMS];
  logic [AtomW-1:0]  nb_mem  [MAX_ATOMS * MAX_BONDS];

  logic              cnt_we, cnt_re;
  logic [AW-1:0]     cnt_waddr, cnt_raddr;
  logic [CountW-1:0] cnt_wdata, cnt_rdata_q;
  logic              nb_we, nb_re;
  logic [NbAw-1:0]   nb_waddr, nb_raddr;
  logic [AtomW-1:0]  nb_rdata_q;

  // walk state
  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic [AtomW-1:0]  atom_q, atom_d;
  logic [AtomW-1:0]  mid_q, mid_d;
  logic [CountW-1:0] c1_q, c1_d, i_q, i_d;
  logic [CountW-1:0] c2_q, c2_d, j_q, j_d;
  logic [NumW-1:0]   n_q, n_d;
  res_item_t         held_q, held_d;
  logic              held_v_q, held_v_d;

  logic [CountW-1:0] i_inc, j_inc;
  logic              hit, mid_ok;

  assign i_inc       = i_q + CountW'(1);
  assign j_inc       = j_q + CountW'(1);
  assign hit         = (atom_q < nb_rdata_q);
  assign mid_ok      = (32'(nb_rdata_q) < 32'(MAX_ATOMS));
  assign init_done_o = (state_q != SClear);

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    atom_d     = atom_q;
    mid_d      = mid_q;
    c1_d       = c1_q;
    i_d        = i_q;
    c2_d       = c2_q;
    j_d        = j_q;
    n_d        = n_q;
    held_d     = held_q;
    held_v_d   = held_v_q;
    cmd_pop_o  = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = '0;
    cnt_wdata  = '0;
    cnt_re     = 1'b0;
    cnt_raddr  = '0;
    nb_we      = 1'b0;
    nb_waddr   = '0;
    nb_re      = 1'b0;
    nb_raddr   = '0;
    res_push_o = 1'b0;
    res_o      = held_q;

    unique case (state_q)
      SClear: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr_q;
        if (clr_addr_q == AW'(MAX_ATOMS - 1)) begin
          state_d = SIdle;
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end

      SIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OpLoad) begin
            if (cmd_i.atom_ok) begin
              cnt_we    = 1'b1;
              cnt_waddr = AW'(cmd_i.atom);
              cnt_wdata = cmd_i.count;
              if (cmd_i.slot_ok) begin
                nb_we    = 1'b1;
                nb_waddr = NbAw'(cmd_i.atom) * NbAw'(MAX_BONDS) + NbAw'(cmd_i.slot);
              end
            end
          end else begin
            atom_d   = cmd_i.atom;
            n_d      = '0;
            held_v_d = 1'b0;
            if (cmd_i.atom_ok) begin
              cnt_re    = 1'b1;
              cnt_raddr = AW'(cmd_i.atom);
              state_d   = SCnt1;
            end else begin
              state_d = SFinish;
            end
          end
        end
      end

      SCnt1: begin
        c1_d = cnt_rdata_q;
        i_d  = '0;
        if (cnt_rdata_q == '0) begin
          state_d = SFinish;
        end else begin
          nb_re    = 1'b1;
          nb_raddr = NbAw'(atom_q) * NbAw'(MAX_BONDS);
          state_d  = SNb1;
        end
      end

      SNb1: begin
        mid_d = nb_rdata_q;
        if (mid_ok) begin
          cnt_re    = 1'b1;
          cnt_raddr = AW'(nb_rdata_q);
          state_d   = SCnt2;
        end else if (i_inc < c1_q) begin
          i_d      = i_inc;
          nb_re    = 1'b1;
          nb_raddr = NbAw'(atom_q) * NbAw'(MAX_BONDS) + NbAw'(i_inc);
        end else begin
          state_d = SFinish;
        end
      end

      SCnt2: begin
        c2_d = cnt_rdata_q;
        j_d  = '0;
        if (cnt_rdata_q != '0) begin
          nb_re    = 1'b1;
          nb_raddr = NbAw'(mid_q) * NbAw'(MAX_BONDS);
          state_d  = SNb2;
        end else if (i_inc < c1_q) begin
          i_d      = i_inc;
          nb_re    = 1'b1;
          nb_raddr = NbAw'(atom_q) * NbAw'(MAX_BONDS) + NbAw'(i_inc);
          state_d  = SNb1;
        end else begin
          state_d = SFinish;
        end
      end

      SNb2: begin
        // a hit flushes any held angle first, so wait while one is held and the queue is full
        if (!(hit && held_v_q && res_full_i)) begin
          if (hit) begin
            res_push_o         = held_v_q;
            res_o.last         = 1'b0;
            held_d.first_atom  = atom_q;
            held_d.middle_atom = mid_q;
            held_d.end_atom    = nb_rdata_q;
            held_d.empty_res   = 1'b0;
            held_d.last        = 1'b0;
            held_v_d           = 1'b1;
            n_d                = n_q + NumW'(1);
          end
          if (hit && (n_q + NumW'(1) == NumW'(ResultLimit))) begin
            state_d = SFinish;
          end else if (j_inc < c2_q) begin
            j_d      = j_inc;
            nb_re    = 1'b1;
            nb_raddr = NbAw'(mid_q) * NbAw'(MAX_BONDS) + NbAw'(j_inc);
          end else if (i_inc < c1_q) begin
            i_d      = i_inc;
            nb_re    = 1'b1;
            nb_raddr = NbAw'(atom_q) * NbAw'(MAX_BONDS) + NbAw'(i_inc);
            state_d  = SNb1;
          end else begin
            state_d = SFinish;
          end
        end
      end

      SFinish: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (held_v_q) begin
            res_o.last = 1'b1;
          end else begin
            res_o.first_atom  = atom_q;
            res_o.middle_atom = '0;
            res_o.end_atom    = '0;
            res_o.empty_res   = 1'b1;
            res_o.last        = 1'b1;
          end
          held_v_d = 1'b0;
          state_d  = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SClear;
      clr_addr_q <= '0;
      held_v_q   <= 1'b0;
      n_q        <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      held_v_q   <= held_v_d;
      n_q        <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    atom_q <= atom_d;
    mid_q  <= mid_d;
    c1_q   <= c1_d;
    i_q    <= i_d;
    c2_q   <= c2_d;
    j_q    <= j_d;
    held_q <= held_d;
  end

  // bond count memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr];
    end
  end

  // neighbour table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (nb_we) begin
      nb_mem[nb_waddr] <= cmd_i.neighbour;
    end
    if (nb_re) begin
      nb_rdata_q <= nb_mem[nb_raddr];
    end
  end

endmodule

// ===== rtl/core/bae_res_queue.sv =====
// bae_res_queue: two-entry result queue between the engine and the receiver
// depends on bae_pkg
module bae_res_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bae_pkg::res_item_t res_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output bae_pkg::res_item_t res_o
);
  import bae_pkg::*;

  res_item_t        q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== tb/tb_bond_angle_enumerator_top.sv =====
// tb_bond_angle_enumerator_top: self-checking testbench of bond_angle_enumerator_top
// loads neighbour tables, enumerates angles and checks every result item
// against its own model of the table; depends on bae_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_bond_angle_enumerator_top;
  import bae_pkg::*;

  localparam int ResetCycles = 9;
  localparam int ItemTarget  = 330;
  // long receiver hold-off, well past what the two queues can absorb
  localparam int HoldCycles  = 400;
  // margin for a queued load plus a worst-case walk
  localparam int TailCycles  = 40;
  // room for the clearing pass over 1024 atoms and all 330 items,
  // taken several times over
  localparam int CycleLimit  = 300000;
  localparam int CountMax    = (1 << CountW) - 1;

  // receiver stall patterns, picked anew at random by the receiver process
  typedef enum logic [1:0] {
    RxFree,
    RxHalf,
    RxSparse,
    RxBursty
  } rx_mode_e;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push   = 1'b0;
  logic       pop    = 1'b0;
  logic       full;
  logic       empty;
  in_item_t   item_i = '0;
  res_item_t  result_o;

  // model of the neighbour table and bond counts
  logic [AtomW-1:0]  nbr_mem     [DefMaxAtoms][DefMaxBonds];
  logic [CountW-1:0] bond_cnt    [DefMaxAtoms] = '{default: '0};
  // slots written so far; loads never set a count that reaches an unwritten slot
  bit                slot_loaded [DefMaxAtoms][DefMaxBonds];

  // angle results still owed by the block, oldest first
  res_item_t angle_q[$];

  int          errors     = 0;
  int          items_sent = 0;
  int unsigned cycle_cnt  = 0;
  // sender pacing: bursts of random length with random gaps
  bit          gap_on     = 1'b1;
  int          burst_left = 0;
  // receiver side
  bit          hold_req   = 1'b0;
  int          hold_left  = 0;
  int unsigned rx_tick    = 0;
  rx_mode_e    rx_mode    = RxFree;

  always #2 clk_i = ~clk_i;

  bond_angle_enumerator_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  // append one owed result item at the tail
  function automatic void owe_result(res_item_t r);
    angle_q = {angle_q, r};
  endfunction

  // update the table on a load, or walk first -> middle -> end on an enumerate
  function automatic void predict_angles(in_item_t it);
    res_item_t        r;
    logic [AtomW-1:0] mid;
    logic [AtomW-1:0] fin;
    int               n;
    if (it.operation == OpLoad) begin
      nbr_mem[it.atom][it.slot]     = it.neighbour;
      slot_loaded[it.atom][it.slot] = 1'b1;
      bond_cnt[it.atom] = (it.bond_count > CountW'(DefMaxBonds)) ?
                          CountW'(DefMaxBonds) : it.bond_count;
      return;
    end
    n = 0;
    for (int i = 0; i < int'(bond_cnt[it.atom]) && n < ResultLimit; i++) begin
      mid = nbr_mem[it.atom][i];
      for (int j = 0; j < int'(bond_cnt[mid]) && n < ResultLimit; j++) begin
        fin = nbr_mem[mid][j];
        if (fin > it.atom) begin
          r = '{first_atom: it.atom, middle_atom: mid, end_atom: fin,
                empty_res: 1'b0, last: 1'b0};
          owe_result(r);
          n++;
        end
      end
    end
    if (n == 0) begin
      r = '{first_atom: it.atom, middle_atom: '0, end_atom: '0,
            empty_res: 1'b1, last: 1'b1};
      owe_result(r);
    end else begin
      // the final angle owed closes the query; at the limit that is the twelfth even when more would follow
      angle_q[angle_q.size()-1].last = 1'b1;
    end
  endfunction

  // highest legal bond count once slot s of atom a is written: the written
  // prefix of slots, or any value once all slots hold a neighbour
  function automatic int count_ceiling(logic [AtomW-1:0] a, int s);
    int p;
    p = 0;
    while (p < DefMaxBonds && (slot_loaded[a][p] || p == s)) p++;
    return (p == DefMaxBonds) ? CountMax : p;
  endfunction

  // four-state compare so unknown bits on the result count as a mismatch
  function automatic void field_check(string name, logic [AtomW-1:0] want,
                                      logic [AtomW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_item(in_item_t it);
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    predict_angles(it);
    items_sent++;
    if (gap_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(0, 15);
      end
    end
  endtask

  task automatic send_load_cnt(logic [AtomW-1:0] a, int s, logic [AtomW-1:0] nbr, int cnt);
    in_item_t it;
    it = '{operation: OpLoad, atom: a, slot: SlotW'(s), neighbour: nbr,
           bond_count: CountW'(cnt)};
    send_item(it);
  endtask

  // mostly the count that grows with the slot, sometimes any legal count
  task automatic send_load(logic [AtomW-1:0] a, int s, logic [AtomW-1:0] nbr);
    int ceil_cnt;
    int cnt;
    ceil_cnt = count_ceiling(a, s);
    if ($urandom_range(0, 5) == 0) cnt = $urandom_range(0, ceil_cnt);
    else cnt = (s + 1 < ceil_cnt) ? s + 1 : ceil_cnt;
    send_load_cnt(a, s, nbr, cnt);
  endtask

  // the unused fields of an enumerate carry random bits
  task automatic send_enum(logic [AtomW-1:0] a);
    in_item_t it;
    it = '{operation: OpEnum, atom: a, slot: SlotW'($urandom),
           neighbour: AtomW'($urandom), bond_count: CountW'($urandom)};
    send_item(it);
  endtask

  // sender stops until every owed result item has come back
  task automatic wait_results_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (angle_q.size() != 0) @(posedge clk_i);
  endtask

  // extremes of the fields and each special case of the walk
  task automatic test_directed_cases();
    // atom 0 bonded four times to atom 1, last count loaded as 7 and clamped
    for (int s = 0; s < DefMaxBonds; s++) send_load_cnt(0, s, 1, (s == 3) ? 7 : s + 1);
    // atom 1 bonded four times to the highest atom
    for (int s = 0; s < DefMaxBonds; s++) send_load_cnt(1, s, 1023, s + 1);
    // sixteen angles found, only twelve sent
    send_enum(0);
    // atom with no bonds
    send_enum(1023);
    // end atom equal to first atom is not an angle
    send_load_cnt(1023, 0, 1, 1);
    send_enum(1023);
    send_enum(1);
    // every end atom below the first
    send_load_cnt(2, 0, 0, 1);
    send_enum(2);
    // exactly twelve angles, the last one marked
    send_load_cnt(0, 0, 2, 4);
    send_enum(0);
    // bond count loaded back to zero
    send_load_cnt(2, 0, 1022, 0);
    send_enum(2);
    // a short list of four angles
    send_load_cnt(3, 0, 1, 1);
    send_enum(3);
    wait_results_drained();
  endtask

  // receiver holds off while the sender keeps offering twelve-angle queries,
  // so the result queue fills, the walk stalls and full rises
  task automatic test_receiver_hold_off();
    gap_on   = 1'b0;
    hold_req = 1'b1;
    repeat (10) send_enum(0);
    gap_on   = 1'b1;
    wait_results_drained();
  endtask

  // small random molecules: pool atoms get in-order neighbour lists mostly
  // drawn from the pool, then most pool atoms are queried; a little noise of
  // stray loads and queries on random atoms
  task automatic test_random_molecules(int target);
    logic [AtomW-1:0] pool[8];
    logic [AtomW-1:0] nbr;
    int               n_pool;
    int               base;
    bit               cluster;
    int               n_bonds;
    while (items_sent < target) begin
      gap_on  = ($urandom_range(0, 3) != 0);
      n_pool  = $urandom_range(3, 8);
      base    = $urandom_range(0, 1023);
      cluster = $urandom_range(0, 1);
      for (int k = 0; k < n_pool; k++)
        pool[k] = cluster ? AtomW'(base + $urandom_range(0, 15)) : AtomW'($urandom);
      for (int k = 0; k < n_pool; k++) begin
        n_bonds = $urandom_range(0, DefMaxBonds);
        for (int s = 0; s < n_bonds; s++) begin
          if ($urandom_range(0, 7) != 0) nbr = pool[$urandom_range(0, n_pool - 1)];
          else nbr = AtomW'($urandom);
          send_load(pool[k], s, nbr);
        end
      end
      repeat ($urandom_range(0, 2))
        send_load(AtomW'($urandom), $urandom_range(0, DefMaxBonds - 1), AtomW'($urandom));
      for (int k = 0; k < n_pool; k++)
        if ($urandom_range(0, 3) != 0) send_enum(pool[k]);
      if ($urandom_range(0, 1) != 0) send_enum(AtomW'($urandom));
      if ($urandom_range(0, 7) == 0) wait_results_drained();
    end
  endtask

  // receiver: check the item taken at this edge, then pick the next pop
  always @(posedge clk_i) begin : result_side
    res_item_t want;
    if (rst_ni && pop && !empty) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, result_o);
        errors++;
      end else begin
        want = angle_q.pop_front();
        field_check("first_atom", want.first_atom, result_o.first_atom);
        field_check("middle_atom", want.middle_atom, result_o.middle_atom);
        field_check("end_atom", want.end_atom, result_o.end_atom);
        field_check("empty_res", want.empty_res, result_o.empty_res);
        field_check("last", want.last, result_o.last);
      end
    end
    rx_tick++;
    if (rx_tick % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        RxFree:   pop <= 1'b1;
        RxHalf:   pop <= $urandom_range(0, 1);
        RxSparse: pop <= ($urandom_range(0, 3) == 0);
        default:  pop <= rx_tick[3];
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("bond_angle_enumerator_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_receiver_hold_off();
    test_random_molecules(ItemTarget);
    wait_results_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0 && angle_q.size() == 0) begin
      $display("bond_angle_enumerator_top verification clean");
    end else begin
      $display("bond_angle_enumerator_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bae_pkg.sv
rtl/core/bae_cmd_queue.sv
rtl/core/bae_engine.sv
rtl/core/bae_res_queue.sv
rtl/core/bond_angle_enumerator_top.sv
tb/tb_bond_angle_enumerator_top.sv
